[rtl/hsv_to_rgb_converter_top_assert.svh]
// Assertion macros shared by the HSV to RGB converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define HSVRGB_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// When the antecedent holds, the consequent must hold at the same edge.
`define HSVRGB_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

`endif

[rtl/hsvrgb_pkg.sv]
// Package with widths, stage types and a helper function of the HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

    localparam int HUE_BITS     = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int SECTORS      = 6;

    localparam int SEC_W = 3;
    localparam int POS_W = HUE_BITS + SEC_W;
    localparam int W_W   = HUE_BITS + 1;
    localparam int C_W   = 2 * CHANNEL_BITS;
    localparam int XS_W  = C_W + W_W;

    localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

    // Sector codes, sixths of the color wheel starting at red.
    localparam logic [SEC_W-1:0] SECT_RED_YELLOW    = SEC_W'(0);
    localparam logic [SEC_W-1:0] SECT_YELLOW_GREEN  = SEC_W'(1);
    localparam logic [SEC_W-1:0] SECT_GREEN_CYAN    = SEC_W'(2);
    localparam logic [SEC_W-1:0] SECT_CYAN_BLUE     = SEC_W'(3);
    localparam logic [SEC_W-1:0] SECT_BLUE_MAGENTA  = SEC_W'(4);
    localparam logic [SEC_W-1:0] SECT_MAGENTA_RED   = SEC_W'(5);

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } pipe_en_t;

    typedef struct packed {
        logic [SEC_W-1:0] sector;
        logic [W_W-1:0]   weight;
        logic [C_W-1:0]   chroma;
        chan_t            v;
    } s1_t;

    typedef struct packed {
        logic [SEC_W-1:0] sector;
        logic [XS_W-1:0]  xs;
        logic [C_W-1:0]   ms;
        chan_t            v;
    } s2_t;

    typedef struct packed {
        logic [SEC_W-1:0] sector;
        logic [C_W-1:0]   qx;
        logic [C_W-1:0]   qz;
        chan_t            ex;
        chan_t            ez;
        chan_t            v;
    } s3_t;

    // Finishes q / CH_MAX from the estimate e = q >> CHANNEL_BITS, which is
    // either the true quotient or one below it.
    function automatic chan_t div_fix(logic [C_W-1:0] q, chan_t e);
        logic [C_W-1:0] prod;
        logic [C_W-1:0] rem;
        prod = {e, {CHANNEL_BITS{1'b0}}} - C_W'(e);
        rem  = q - prod;
        if (rem >= C_W'(CH_MAX)) begin
            div_fix = e + chan_t'(1);
        end else begin
            div_fix = e;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/hsvrgb_chroma.sv]
// First stage: hue sector, sector weight and chroma.
`default_nettype none

module hsvrgb_chroma (
    input  wire logic                               clk,
    input  wire hsvrgb_pkg::pipe_en_t               en,
    input  wire logic [hsvrgb_pkg::HUE_BITS-1:0]    hue,
    input  wire logic [hsvrgb_pkg::CHANNEL_BITS-1:0] saturation,
    input  wire logic [hsvrgb_pkg::CHANNEL_BITS-1:0] brightness,
    output hsvrgb_pkg::s1_t                         s1
);
    import hsvrgb_pkg::*;

    logic [POS_W-1:0]    pos;
    logic [HUE_BITS-1:0] frac;
    s1_t                 s1_next;
    s1_t                 s1_reg;

    always_comb
    begin
        pos            = POS_W'(hue) * POS_W'(SECTORS);
        frac           = pos[HUE_BITS-1:0];
        s1_next.sector = pos[POS_W-1:HUE_BITS];
        // Odd sectors fall from full weight toward zero.
        if (s1_next.sector[0]) begin
            s1_next.weight = (W_W'(1) << HUE_BITS) - W_W'(frac);
        end else begin
            s1_next.weight = W_W'(frac);
        end
        s1_next.chroma = C_W'(saturation) * C_W'(brightness);
        s1_next.v      = brightness;
    end

    always_ff @(posedge clk)
    begin
        if (en.en1) begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

[rtl/hsvrgb_mix.sv]
// Second and third stages: secondary term, offset and quotient estimates.
`default_nettype none

module hsvrgb_mix (
    input  wire logic                 clk,
    input  wire hsvrgb_pkg::pipe_en_t en,
    input  wire hsvrgb_pkg::s1_t      s1,
    output hsvrgb_pkg::s3_t           s3
);
    import hsvrgb_pkg::*;

    s2_t s2_next;
    s2_t s2_reg;
    s3_t s3_next;
    s3_t s3_reg;

    always_comb
    begin
        s2_next.sector = s1.sector;
        s2_next.xs     = XS_W'(s1.chroma) * XS_W'(s1.weight);
        // Offset m = v*MAX - c, kept in units of 1/MAX^2.
        s2_next.ms     = ({s1.v, {CHANNEL_BITS{1'b0}}} - C_W'(s1.v)) - s1.chroma;
        s2_next.v      = s1.v;
    end

    always_comb
    begin
        s3_next.sector = s2_reg.sector;
        s3_next.qx     = s2_reg.ms + s2_reg.xs[HUE_BITS+C_W-1:HUE_BITS];
        s3_next.qz     = s2_reg.ms;
        s3_next.ex     = s3_next.qx[C_W-1:CHANNEL_BITS];
        s3_next.ez     = s2_reg.ms[C_W-1:CHANNEL_BITS];
        s3_next.v      = s2_reg.v;
    end

    always_ff @(posedge clk)
    begin
        if (en.en2) begin
            s2_reg <= s2_next;
        end
        if (en.en3) begin
            s3_reg <= s3_next;
        end
    end

    assign s3 = s3_reg;

endmodule

`default_nettype wire

[rtl/hsvrgb_place.sv]
// Fourth stage: quotient correction and channel placement by sector.
`default_nettype none

module hsvrgb_place (
    input  wire logic                                clk,
    input  wire hsvrgb_pkg::pipe_en_t                en,
    input  wire hsvrgb_pkg::s3_t                     s3,
    output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]      red,
    output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]      green,
    output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]      blue
);
    import hsvrgb_pkg::*;

    chan_t xval;
    chan_t zval;
    chan_t red_next;
    chan_t green_next;
    chan_t blue_next;
    chan_t red_reg;
    chan_t green_reg;
    chan_t blue_reg;

    always_comb
    begin
        xval = div_fix(s3.qx, s3.ex);
        zval = div_fix(s3.qz, s3.ez);
        // The chroma channel plus offset is exactly the brightness.
        case (s3.sector)
            SECT_RED_YELLOW:
            begin
                red_next = s3.v; green_next = xval; blue_next = zval;
            end
            SECT_YELLOW_GREEN:
            begin
                red_next = xval; green_next = s3.v; blue_next = zval;
            end
            SECT_GREEN_CYAN:
            begin
                red_next = zval; green_next = s3.v; blue_next = xval;
            end
            SECT_CYAN_BLUE:
            begin
                red_next = zval; green_next = xval; blue_next = s3.v;
            end
            SECT_BLUE_MAGENTA:
            begin
                red_next = xval; green_next = zval; blue_next = s3.v;
            end
            default:
            begin
                red_next = s3.v; green_next = zval; blue_next = xval;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.en4) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

[rtl/hsv_to_rgb_converter_top.sv]
// An input transfer is registered in each stage in turn before the result is offered.
// Throughput: one pixel per cycle while out_ready is not held low; each of the four stages holds one pixel.
// Stages: sector and chroma, weight multiply, quotient estimate, correction.
// A stalled output stage lets upstream stages keep filling any free slot.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none

`include "hsv_to_rgb_converter_top_assert.svh"

module hsv_to_rgb_converter_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [hsvrgb_pkg::HUE_BITS-1:0]     hue,
    input  wire logic [hsvrgb_pkg::CHANNEL_BITS-1:0] saturation,
    input  wire logic [hsvrgb_pkg::CHANNEL_BITS-1:0] brightness,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]      red,
    output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]      green,
    output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]      blue
);
    import hsvrgb_pkg::*;

    logic [3:0] valid_reg;
    logic [3:0] valid_next;
    pipe_en_t   en;
    s1_t        s1;
    s3_t        s3;

    // A stage loads when it is empty or its contents move on this cycle.
    always_comb
    begin
        en.en4 = !valid_reg[3] || out_ready;
        en.en3 = !valid_reg[2] || en.en4;
        en.en2 = !valid_reg[1] || en.en3;
        en.en1 = !valid_reg[0] || en.en2;
        valid_next[0] = en.en1 ? in_valid     : valid_reg[0];
        valid_next[1] = en.en2 ? valid_reg[0] : valid_reg[1];
        valid_next[2] = en.en3 ? valid_reg[1] : valid_reg[2];
        valid_next[3] = en.en4 ? valid_reg[2] : valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en.en1;
    assign out_valid = valid_reg[3];

    hsvrgb_chroma u_chroma (
        .clk        (clk),
        .en         (en),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .s1         (s1)
    );

    hsvrgb_mix u_mix (
        .clk (clk),
        .en  (en),
        .s1  (s1),
        .s3  (s3)
    );

    hsvrgb_place u_place (
        .clk   (clk),
        .en    (en),
        .s3    (s3),
        .red   (red),
        .green (green),
        .blue  (blue)
    );

    // Input is refused only when every stage is full and the output is stalled.
    `HSVRGB_ASSERT_IMPLIES(a_ready_only_when_full, !in_ready,
        (valid_reg == 4'b1111) && !out_ready)
    // The hue position never reaches a seventh sector.
    `HSVRGB_ASSERT_IMPLIES(a_sector_range, valid_reg[0],
        s1.sector <= SECT_MAGENTA_RED)
    // The secondary quotient lies between the offset quotient and brightness shifted up by CHANNEL_BITS.
    `HSVRGB_ASSERT_IMPLIES(a_quotient_bound, valid_reg[2],
        (s3.qx >= s3.qz) && (s3.qx <= {s3.v, {CHANNEL_BITS{1'b0}}}))

endmodule

`default_nettype wire
